[src/lrmt_pkg.sv]
// Shared command and status codes for the line range map table.
// No dependencies.
package lrmt_pkg;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_POKE   = 2'd1,
    CMD_NEXT   = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_AFTER = 2'd2,
    ST_NOMAP = 2'd3
  } status_t;

endpackage

[src/line_range_map_table_core.sv]
// Line range map table: virtual line counter and append-only mapping table
// held in one synchronous memory, searched by a sequential binary search.
// Depends on lrmt_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | command, file_given, file_id,
//          |                      | base_file_line, increment, query_line
//  out     | out_valid / out_ready| current_line, returned_line, found_file_id,
//          |                      | found_file_line, status
//
// Poke makes two table writes on the one write port. A flagged lookup skips
// the search; otherwise each search probe is one memory read plus a compare,
// then come a final read, a subtract, an 8x32 multiply and an add. The table
// is not cleared by reset. The output register lets a new request in while a
// result waits.
module line_range_map_table_core #(
  parameter int TABLE_DEPTH  = 256,
  parameter int FILE_ID_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic        file_given,
  input  logic [7:0]  file_id,
  input  logic [31:0] base_file_line,
  input  logic [7:0]  increment,
  input  logic [31:0] query_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] current_line,
  output logic [31:0] returned_line,
  output logic [7:0]  found_file_id,
  output logic [31:0] found_file_line,
  output logic [1:0]  status
);
  import lrmt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] POKE_LIM   = CNT_W'(TABLE_DEPTH - 2);
  localparam logic [CNT_W-1:0] STRIDE_TOP = {1'b1, {(CNT_W-1){1'b0}}};

  typedef struct packed {
    logic [31:0]             start;
    logic [FILE_ID_BITS-1:0] file;
    logic [31:0]             base;
    logic [7:0]              step;
  } entry_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_POKE2 = 8'b0000_0010,
    S_SRCH  = 8'b0000_0100,
    S_CMP   = 8'b0000_1000,
    S_FWAIT = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_ADD   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;

  state_t                  state;
  logic [31:0]             vl;
  logic [CNT_W-1:0]        count;
  logic [FILE_ID_BITS-1:0] last_file;
  logic [31:0]             first_start;
  logic [31:0]             base_r;
  logic [31:0]             q_r;
  logic [IDX_W-1:0]        idx;
  logic [CNT_W-1:0]        stride;
  logic [31:0]             diff;
  logic [7:0]              fstep;
  logic [31:0]             fbase;
  logic [39:0]             prod;
  logic [31:0]             res_ret;
  logic [FILE_ID_BITS-1:0] res_file;
  logic [31:0]             res_fline;
  status_t                 res_status;

  cmd_t                    cmd;
  logic                    accept;
  logic                    set_full;
  logic                    poke_full;
  logic                    out_free;
  logic [FILE_ID_BITS+7:0] fid_ext;
  logic [FILE_ID_BITS+7:0] fout_ext;
  logic [FILE_ID_BITS-1:0] prev_file;
  logic [FILE_ID_BITS-1:0] file_sel;
  logic [CNT_W:0]          probe;
  logic                    probe_ok;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  entry_t                  mem_wdata;
  logic                    mem_re;
  logic [IDX_W-1:0]        mem_raddr;

  assign cmd       = cmd_t'(command);
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign set_full  = (count >= DEPTH_C);
  assign poke_full = (count > POKE_LIM);
  assign out_free  = !out_valid || out_ready;
  assign fid_ext   = {{FILE_ID_BITS{1'b0}}, file_id};
  assign fout_ext  = {8'b0, res_file};
  assign prev_file = (count == '0) ? '0 : last_file;
  assign file_sel  = file_given ? fid_ext[FILE_ID_BITS-1:0] : prev_file;
  assign probe     = (CNT_W+1)'(idx) + (CNT_W+1)'(stride);
  assign probe_ok  = (probe < (CNT_W+1)'(count));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[IDX_W-1:0];
    mem_wdata = '{start: vl, file: file_sel, base: base_file_line, step: increment};
    mem_re    = 1'b0;
    mem_raddr = probe[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept && cmd == CMD_SET && !set_full) begin
          mem_we = 1'b1;
        end else if (accept && cmd == CMD_POKE && !poke_full) begin
          mem_we    = 1'b1;
          mem_wdata = '{start: vl + 32'd1, file: file_sel, base: base_file_line, step: 8'd0};
        end
      end
      S_POKE2: begin
        mem_we    = 1'b1;
        mem_wdata = '{start: vl + 32'd1, file: last_file, base: base_r, step: 8'd0};
      end
      S_SRCH: begin
        if (stride == '0) begin
          mem_re    = 1'b1;
          mem_raddr = idx;
        end else if (probe_ok) begin
          mem_re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vl        <= 32'd1;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_ret    <= '0;
            res_file   <= '0;
            res_fline  <= '0;
            res_status <= ST_OK;
            base_r     <= base_file_line;
            q_r        <= query_line;
            idx        <= '0;
            stride     <= STRIDE_TOP;
            state      <= S_DONE;
            unique case (cmd)
              CMD_SET: begin
                if (set_full) begin
                  res_status <= ST_FULL;
                end else begin
                  if (count == '0) begin
                    first_start <= vl;
                  end
                  last_file <= file_sel;
                  count     <= count + 1'b1;
                end
              end
              CMD_POKE: begin
                if (poke_full) begin
                  res_status <= ST_FULL;
                end else begin
                  if (count == '0) begin
                    first_start <= vl + 32'd1;
                  end
                  last_file <= file_sel;
                  count     <= count + 1'b1;
                  vl        <= vl + 32'd1;
                  res_ret   <= vl + 32'd1;
                  state     <= S_POKE2;
                end
              end
              CMD_NEXT: begin
                vl      <= vl + 32'd1;
                res_ret <= vl + 32'd1;
              end
              CMD_LOOKUP: begin
                if (query_line > vl) begin
                  res_status <= ST_AFTER;
                end else if (count == '0 || query_line < first_start) begin
                  res_status <= ST_NOMAP;
                end else begin
                  state <= S_SRCH;
                end
              end
            endcase
          end
        end
        S_POKE2: begin
          count <= count + 1'b1;
          vl    <= vl + 32'd1;
          state <= S_DONE;
        end
        S_SRCH: begin
          if (stride == '0) begin
            state <= S_FWAIT;
          end else if (probe_ok) begin
            state <= S_CMP;
          end else begin
            stride <= stride >> 1;
          end
        end
        S_CMP: begin
          if (rd_data.start <= q_r) begin
            idx <= probe[IDX_W-1:0];
          end
          stride <= stride >> 1;
          state  <= S_SRCH;
        end
        S_FWAIT: begin
          diff     <= q_r - rd_data.start;
          fstep    <= rd_data.step;
          fbase    <= rd_data.base;
          res_file <= rd_data.file;
          state    <= S_MUL;
        end
        S_MUL: begin
          prod  <= 40'(fstep) * 40'(diff);
          state <= S_ADD;
        end
        S_ADD: begin
          res_fline <= fbase + prod[31:0];
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            current_line    <= vl;
            returned_line   <= res_ret;
            found_file_id   <= fout_ext[7:0];
            found_file_line <= res_fline;
            status          <= res_status;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[verif/tb.sv]
// Testbench for line_range_map_table_core: directed rows, then random requests,
// checked against typed row values or an in-bench model of the line counter and
// mapping table. Depends on lrmt_pkg and line_range_map_table_core.
module tb;
  import lrmt_pkg::*;

  localparam int          DEPTH        = 256;
  localparam int          RANDOM_ITEMS = 1026;
  localparam int          HOLD_AFTER   = 200;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_AT     = 500;
  localparam logic [7:0]  UNKNOWN_FILE = 8'd0;

  typedef struct {
    cmd_t        cmd;
    logic        given;
    logic [7:0]  fid;
    logic [31:0] base;
    logic [7:0]  inc;
    logic [31:0] q;
  } request_t;

  typedef struct {
    logic [31:0] cur_line;
    logic [31:0] ret_line;
    logic [7:0]  src_file;
    logic [31:0] src_line;
    status_t     st;
  } result_t;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  res;
  } row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic        file_given;
  logic [7:0]  file_id;
  logic [31:0] base_file_line;
  logic [7:0]  increment;
  logic [31:0] query_line;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] current_line;
  logic [31:0] returned_line;
  logic [7:0]  found_file_id;
  logic [31:0] found_file_line;
  logic [1:0]  status;

  line_range_map_table_core dut (.*);

  // line counter and mapping table as the block should hold them
  logic [31:0] line_ctr;
  int unsigned map_count;
  logic [31:0] map_start [DEPTH];
  logic [7:0]  map_file  [DEPTH];
  logic [31:0] map_base  [DEPTH];
  logic [7:0]  map_step  [DEPTH];

  result_t     pending_results [$];
  row_t        directed_rows [$];
  int unsigned mismatches;
  int unsigned results_seen;
  bit          short_poke_done;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #4000000;
    $display("line_range_map_table_core verification failed");
    $finish;
  end

  function automatic void add_mapping(logic given, logic [7:0] fid, logic [31:0] base,
                                      logic [7:0] step);
    logic [7:0] f;
    if (given) f = fid;
    else if (map_count > 0) f = map_file[map_count - 1];
    else f = UNKNOWN_FILE;
    map_start[map_count] = line_ctr;
    map_file[map_count]  = f;
    map_base[map_count]  = base;
    map_step[map_count]  = step;
    map_count++;
  endfunction

  function automatic result_t apply_command(request_t r);
    result_t     res;
    int unsigned idx;
    int unsigned stride;
    logic [31:0] offset;
    res.ret_line = '0;
    res.src_file = '0;
    res.src_line = '0;
    res.st       = ST_OK;
    case (r.cmd)
      CMD_SET: begin
        if (map_count >= DEPTH) res.st = ST_FULL;
        else add_mapping(r.given, r.fid, r.base, r.inc);
      end
      CMD_POKE: begin
        if (map_count + 2 > DEPTH) res.st = ST_FULL;
        else begin
          line_ctr = line_ctr + 1;
          add_mapping(r.given, r.fid, r.base, 8'd0);
          res.ret_line = line_ctr;
          line_ctr = line_ctr + 1;
          add_mapping(1'b1, map_file[map_count - 1], map_base[map_count - 1], 8'd0);
        end
      end
      CMD_NEXT: begin
        line_ctr = line_ctr + 1;
        res.ret_line = line_ctr;
      end
      default: begin
        if (r.q > line_ctr) res.st = ST_AFTER;
        else if (map_count == 0 || r.q < map_start[0]) res.st = ST_NOMAP;
        else begin
          idx = 0;
          stride = 1;
          while (stride * 2 <= map_count) stride = stride * 2;
          while (stride > 0) begin
            if (idx + stride < map_count && map_start[idx + stride] <= r.q) idx += stride;
            stride = stride / 2;
          end
          offset = r.q - map_start[idx];
          res.src_file = map_file[idx];
          res.src_line = map_base[idx] + {24'd0, map_step[idx]} * offset;
        end
      end
    endcase
    res.cur_line = line_ctr;
    return res;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r.given = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: r.fid = 8'h00;
      1: r.fid = 8'hFF;
      default: r.fid = 8'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: r.base = 32'h0;
      1: r.base = 32'hFFFF_FFFF;
      default: r.base = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: r.inc = 8'h00;
      1: r.inc = 8'hFF;
      default: r.inc = 8'($urandom);
    endcase
    r.q = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 15) r.cmd = CMD_SET;
    else if (pick < 25) r.cmd = CMD_POKE;
    else if (pick < 50) r.cmd = CMD_NEXT;
    else r.cmd = CMD_LOOKUP;
    // walk the table through one free entry and try a poke there
    if (map_count == DEPTH - 2) r.cmd = CMD_SET;
    else if (map_count == DEPTH - 1 && !short_poke_done) begin
      r.cmd = CMD_POKE;
      short_poke_done = 1'b1;
    end
    if (r.cmd == CMD_LOOKUP) begin
      case ($urandom_range(0, 9))
        0: r.q = $urandom;
        1: r.q = line_ctr + 1;
        2: r.q = line_ctr;
        3: if (map_count > 0) r.q = map_start[$urandom_range(0, map_count - 1)];
        4: if (map_count > 0) r.q = map_start[$urandom_range(0, map_count - 1)] - 1;
        5: r.q = 32'h0;
        default: r.q = $urandom_range(0, line_ctr);
      endcase
    end
    return r;
  endfunction

  task automatic add_row(cmd_t c, logic g, logic [7:0] f, logic [31:0] b, logic [7:0] n,
                         logic [31:0] q, bit typed, logic [31:0] cur, logic [31:0] ret,
                         logic [7:0] ffid, logic [31:0] fline, status_t st);
    row_t row;
    row.req   = '{c, g, f, b, n, q};
    row.typed = typed;
    row.res   = '{cur, ret, ffid, fline, st};
    directed_rows.push_back(row);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("current_line", want.cur_line, current_line);
        check_field("returned_line", want.ret_line, returned_line);
        check_field("found_file_id", 32'(want.src_file), 32'(found_file_id));
        check_field("found_file_line", want.src_line, found_file_line);
        check_field("status", 32'(want.st), 32'(status));
      end
    end
  end

  initial begin
    int unsigned mode;
    int unsigned mode_left;
    bit          held;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (mode_left % 8) < 5;
        endcase
      end
    end
  end

  initial begin
    request_t    r;
    result_t     want;
    int unsigned burst_left;
    int unsigned gap;
    int unsigned total;
    rst             = 1'b1;
    in_valid        = 1'b0;
    command         = CMD_SET;
    file_given      = 1'b0;
    file_id         = '0;
    base_file_line  = '0;
    increment       = '0;
    query_line      = '0;
    line_ctr        = 32'd1;
    map_count       = 0;
    mismatches      = 0;
    results_seen    = 0;
    short_poke_done = 1'b0;
    burst_left      = 0;

    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'h0, 1, 32'd1, 32'd0, 8'h00, 32'h0, ST_NOMAP);
    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'hFFFF_FFFF,
            1, 32'd1, 32'd0, 8'h00, 32'h0, ST_AFTER);
    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'd2, 1, 32'd1, 32'd0, 8'h00, 32'h0, ST_AFTER);
    add_row(CMD_NEXT, 0, 8'h00, 32'h0, 8'h00, 32'h0, 1, 32'd2, 32'd2, 8'h00, 32'h0, ST_OK);
    add_row(CMD_SET, 0, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'h0,
            1, 32'd2, 32'd0, 8'h00, 32'h0, ST_OK);
    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'd1, 1, 32'd2, 32'd0, 8'h00, 32'h0, ST_NOMAP);
    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'd2,
            1, 32'd2, 32'd0, 8'h00, 32'hFFFF_FFFF, ST_OK);
    add_row(CMD_NEXT, 0, 8'h00, 32'h0, 8'h00, 32'h0, 1, 32'd3, 32'd3, 8'h00, 32'h0, ST_OK);
    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'd3, 0, 32'd0, 32'd0, 8'h00, 32'h0, ST_OK);
    add_row(CMD_SET, 1, 8'hFF, 32'h0, 8'h00, 32'h0, 1, 32'd3, 32'd0, 8'h00, 32'h0, ST_OK);
    add_row(CMD_SET, 0, 8'h00, 32'h8000_0000, 8'h01, 32'h0,
            1, 32'd3, 32'd0, 8'h00, 32'h0, ST_OK);
    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'd3, 0, 32'd0, 32'd0, 8'h00, 32'h0, ST_OK);
    add_row(CMD_POKE, 1, 8'h5A, 32'h1234_5678, 8'hAB, 32'h0,
            1, 32'd5, 32'd4, 8'h00, 32'h0, ST_OK);
    add_row(CMD_POKE, 0, 8'hA5, 32'hEDCB_A987, 8'h00, 32'h0,
            1, 32'd7, 32'd6, 8'h00, 32'h0, ST_OK);
    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'd4, 0, 32'd0, 32'd0, 8'h00, 32'h0, ST_OK);
    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'd7, 0, 32'd0, 32'd0, 8'h00, 32'h0, ST_OK);
    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'd8, 1, 32'd7, 32'd0, 8'h00, 32'h0, ST_AFTER);
    add_row(CMD_NEXT, 0, 8'h00, 32'h0, 8'h00, 32'h0, 1, 32'd8, 32'd8, 8'h00, 32'h0, ST_OK);
    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'd8, 0, 32'd0, 32'd0, 8'h00, 32'h0, ST_OK);
    add_row(CMD_SET, 1, 8'h01, 32'h1, 8'h80, 32'h0, 1, 32'd8, 32'd0, 8'h00, 32'h0, ST_OK);
    add_row(CMD_NEXT, 0, 8'h00, 32'h0, 8'h00, 32'h0, 0, 32'd0, 32'd0, 8'h00, 32'h0, ST_OK);
    add_row(CMD_NEXT, 0, 8'h00, 32'h0, 8'h00, 32'h0, 0, 32'd0, 32'd0, 8'h00, 32'h0, ST_OK);
    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'd10, 0, 32'd0, 32'd0, 8'h00, 32'h0, ST_OK);
    add_row(CMD_LOOKUP, 0, 8'h00, 32'h0, 8'h00, 32'h0, 1, 32'd10, 32'd0, 8'h00, 32'h0, ST_NOMAP);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    total = directed_rows.size() + RANDOM_ITEMS;
    for (int i = 0; i < total; i++) begin
      // let everything drain once before carrying on
      if (i == directed_rows.size() + DRAIN_AT) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      if (i < directed_rows.size()) r = directed_rows[i].req;
      else r = random_request();
      in_valid       <= 1'b1;
      command        <= r.cmd;
      file_given     <= r.given;
      file_id        <= r.fid;
      base_file_line <= r.base;
      increment      <= r.inc;
      query_line     <= r.q;
      do @(posedge clk); while (!in_ready);
      want = apply_command(r);
      if (i < directed_rows.size() && directed_rows[i].typed) want = directed_rows[i].res;
      pending_results.push_back(want);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("line_range_map_table_core verification clean");
    end else begin
      $display("line_range_map_table_core verification failed");
    end
    $finish;
  end

endmodule
